// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the PWM tone sequencer
// Command codes, play modes, the note table entry layout and the
// fixed sizes of the shared divider.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Command codes carried by one input transfer.
    typedef enum logic [2:0] {
        CMD_CARRIER = 3'd0,
        CMD_MS_TICK = 3'd1,
        CMD_OFF     = 3'd2,
        CMD_TONE    = 3'd3,
        CMD_SONG    = 3'd4,
        CMD_SWEEP   = 3'd5,
        CMD_LOAD    = 3'd6
    } cmd_t;

    // Play modes of the interval timer.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TONE  = 2'd1,
        MODE_SONG  = 2'd2,
        MODE_SWEEP = 2'd3
    } mode_t;

    // One note table entry.
    typedef struct packed {
        logic [15:0] freq;
        logic [7:0]  level;
        logic [15:0] dur;
    } note_t;

    // Milliseconds in one minute, and 1/8 beat as a shift (beat / 8 per ms base).
    localparam int MS_PER_MINUTE  = 60000;
    localparam int BEAT_DIV_SHIFT = 3;

    // Shared restoring divider: one quotient bit per cycle.
    localparam int DIV_W     = 16;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

// File: rtl/pwm_tone_sequencer.sv
// ----------------------------------------------------------------------------
// pwm_tone_sequencer: square-wave tone, song and sweep generator
// Drives an 8-bit PWM duty value from carrier and millisecond ticks,
// with a loadable note table and a shared iterative divider.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------
//  input    | in        | in_valid / in_stall | cmd freq level duration speed
//           |           |                     | tempo_bpm direction note_index
//  output   | out       | out_valid/out_stall | duty active
//
//  Carrier ticks, off, tone starts, note loads and most ms ticks finish in idle.
//  An ms tick that ends a song beat uses S_BEAT, S_NEXT, S_ZERO as needed (note RAM read).
//  Song start and sweep start wait in S_DIV on the 16-step divider.
//  Every input transfer yields one output transfer through the output register.
//  Reset clears the control state, not the held command, divider datapath or note table.
//  A stalled output register holds its value and stalls the input side.
//
module pwm_tone_sequencer #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pts_pkg::cmd_t  cmd,
    input  logic [15:0]    freq,
    input  logic [7:0]     level,
    input  logic [15:0]    duration,
    input  logic [15:0]    speed,
    input  logic [7:0]     tempo_bpm,
    input  logic           direction,
    input  logic [5:0]     note_index,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     duty,
    output logic           active
);

    import pts_pkg::*;

    localparam int ADDR_W = $clog2(NOTE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_BEAT,
        S_NEXT,
        S_ZERO,
        S_DONE
    } state_t;

    // Control state.
    state_t               state_reg,         state_next;
    mode_t                mode_reg,          mode_next;
    logic [15:0]          half_period_reg,   half_period_next;
    logic [15:0]          carrier_count_reg, carrier_count_next;
    logic [7:0]           cur_level_reg,     cur_level_next;
    logic [7:0]           duty_val_reg,      duty_val_next;
    logic                 enabled_reg,       enabled_next;
    logic [15:0]          ms_count_reg,      ms_count_next;
    logic [15:0]          ms_period_reg,     ms_period_next;
    logic [15:0]          beat_count_reg,    beat_count_next;
    logic [ADDR_W-1:0]    note_ptr_reg,      note_ptr_next;
    logic [15:0]          sweep_step_reg,    sweep_step_next;
    logic [15:0]          sweep_total_reg,   sweep_total_next;
    logic [15:0]          sweep_base_reg,    sweep_base_next;
    logic                 sweep_up_reg,      sweep_up_next;
    logic [7:0]           sweep_level_reg,   sweep_level_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,       div_cnt_next;
    logic                 out_valid_reg,     out_valid_next;
    logic [7:0]           out_duty_reg,      out_duty_next;
    logic                 out_active_reg,    out_active_next;

    // Command held for the divider result, and the divider datapath.
    cmd_t                 arg_cmd_reg;
    logic [DIV_W:0]       div_rem_reg;
    logic [DIV_W-1:0]     div_quo_reg;
    logic [DIV_W-1:0]     div_den_reg;

    // Handshake and helper values.
    logic                 out_free;
    logic                 in_acc;
    logic [15:0]          speed_c;
    logic [7:0]           tempo_c;
    logic [15:0]          cc_inc;
    logic [15:0]          ms_inc;
    logic [15:0]          beat_inc;
    logic [15:0]          step_inc;
    logic [15:0]          sweep_freq;
    logic [ADDR_W-1:0]    ptr_wrap;
    logic [DIV_W:0]       rem_shift;
    logic                 rem_ge;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dvd;
    logic [DIV_W-1:0]     div_dsr;
    logic                 fast_done;

    // Note table memory.
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [$bits(note_t)-1:0] ram_rd_data;
    note_t                rd_note;

    // Table index reduced modulo the table depth, as a constant table over every index.
    function automatic logic [ADDR_W-1:0] wrap_index(logic [5:0] idx);
        logic [ADDR_W-1:0] addr;
        int                cnt;
        addr = '0;
        cnt  = 0;
        for (int k = 0; k < 64; k++)
        begin
            if (idx == 6'(k))
            begin
                addr = ADDR_W'(cnt);
            end
            cnt = (cnt == NOTE_DEPTH - 1) ? 0 : cnt + 1;
        end
        return addr;
    endfunction

    pts_ram #(
        .WIDTH ($bits(note_t)),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({freq, level, duration}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_note = note_t'(ram_rd_data);

    // Handshake: a result waits in the output register; the input is taken in idle only.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign duty      = out_duty_reg;
    assign active    = out_active_reg;

    // Zero speed and tempo are clamped to one.
    assign speed_c = (speed == 16'd0) ? 16'd1 : speed;
    assign tempo_c = (tempo_bpm == 8'd0) ? 8'd1 : tempo_bpm;

    // Counter increments and sweep frequency.
    assign cc_inc     = carrier_count_reg + 16'd1;
    assign ms_inc     = ms_count_reg + 16'd1;
    assign beat_inc   = beat_count_reg + 16'd1;
    assign step_inc   = sweep_step_reg + 16'd1;
    assign sweep_freq = sweep_up_reg ? (sweep_base_reg + step_inc)
                                     : (sweep_base_reg - step_inc);
    assign ptr_wrap   = (note_ptr_reg == ADDR_W'(NOTE_DEPTH - 1)) ? '0
                                                                  : note_ptr_reg + ADDR_W'(1);

    // One restoring divider step.
    assign rem_shift = {div_rem_reg[DIV_W-1:0], div_quo_reg[DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_den_reg});

    // Sequencer and command decode.
    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        half_period_next   = half_period_reg;
        carrier_count_next = carrier_count_reg;
        cur_level_next     = cur_level_reg;
        duty_val_next      = duty_val_reg;
        enabled_next       = enabled_reg;
        ms_count_next      = ms_count_reg;
        ms_period_next     = ms_period_reg;
        beat_count_next    = beat_count_reg;
        note_ptr_next      = note_ptr_reg;
        sweep_step_next    = sweep_step_reg;
        sweep_total_next   = sweep_total_reg;
        sweep_base_next    = sweep_base_reg;
        sweep_up_next      = sweep_up_reg;
        sweep_level_next   = sweep_level_reg;
        div_cnt_next       = div_cnt_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_duty_next      = out_duty_reg;
        out_active_next    = out_active_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = '0;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = note_ptr_reg;
        div_start          = 1'b0;
        div_dvd            = '0;
        div_dsr            = '0;
        fast_done          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    fast_done = 1'b1;
                    unique case (cmd)
                        CMD_CARRIER:
                        begin
                            if (enabled_reg)
                            begin
                                if (cc_inc >= half_period_reg)
                                begin
                                    carrier_count_next = 16'd0;
                                    duty_val_next = (duty_val_reg != 8'd0) ? 8'd0
                                                                           : cur_level_reg;
                                end
                                else
                                begin
                                    carrier_count_next = cc_inc;
                                end
                            end
                        end
                        CMD_MS_TICK:
                        begin
                            if (mode_reg != MODE_IDLE)
                            begin
                                if (ms_inc >= ms_period_reg)
                                begin
                                    ms_count_next = 16'd0;
                                    unique case (mode_reg)
                                        MODE_TONE:
                                        begin
                                            duty_val_next = 8'd0;
                                            enabled_next  = 1'b0;
                                            mode_next     = MODE_IDLE;
                                        end
                                        MODE_SONG:
                                        begin
                                            // Fetch the current note to check its length.
                                            ram_rd_en   = 1'b1;
                                            ram_rd_addr = note_ptr_reg;
                                            fast_done   = 1'b0;
                                            state_next  = S_BEAT;
                                        end
                                        MODE_SWEEP:
                                        begin
                                            if (sweep_step_reg < sweep_total_reg)
                                            begin
                                                sweep_step_next  = step_inc;
                                                half_period_next = {1'b0, sweep_freq[15:1]};
                                                cur_level_next   = sweep_level_reg;
                                                if (step_inc == sweep_total_reg)
                                                begin
                                                    duty_val_next = 8'd0;
                                                    enabled_next  = 1'b0;
                                                    mode_next     = MODE_IDLE;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                                else
                                begin
                                    ms_count_next = ms_inc;
                                end
                            end
                        end
                        CMD_OFF:
                        begin
                            duty_val_next = 8'd0;
                            enabled_next  = 1'b0;
                            mode_next     = MODE_IDLE;
                        end
                        CMD_TONE:
                        begin
                            half_period_next = {1'b0, freq[15:1]};
                            cur_level_next   = level;
                            duty_val_next    = level;
                            enabled_next     = 1'b1;
                            ms_count_next    = 16'd0;
                            ms_period_next   = duration;
                            mode_next        = MODE_TONE;
                        end
                        CMD_SONG:
                        begin
                            // Beat length comes from the divider, the first note from the RAM.
                            carrier_count_next = 16'd0;
                            ms_count_next      = 16'd0;
                            beat_count_next    = 16'd0;
                            note_ptr_next      = '0;
                            mode_next          = MODE_SONG;
                            ram_rd_en          = 1'b1;
                            ram_rd_addr        = '0;
                            div_start          = 1'b1;
                            div_dvd            = DIV_W'(MS_PER_MINUTE);
                            div_dsr            = DIV_W'(tempo_c) << BEAT_DIV_SHIFT;
                            fast_done          = 1'b0;
                        end
                        CMD_SWEEP:
                        begin
                            // Step total comes from the divider.
                            sweep_step_next  = 16'd0;
                            sweep_base_next  = freq;
                            sweep_up_next    = direction;
                            sweep_level_next = level;
                            half_period_next = {1'b0, freq[15:1]};
                            cur_level_next   = level;
                            duty_val_next    = level;
                            enabled_next     = 1'b1;
                            ms_count_next    = 16'd0;
                            ms_period_next   = speed_c;
                            mode_next        = MODE_SWEEP;
                            div_start        = 1'b1;
                            div_dvd          = duration;
                            div_dsr          = speed_c;
                            fast_done        = 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            // The note is written straight from the transfer.
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = wrap_index(note_index);
                        end
                        default:
                        begin
                        end
                    endcase

                    if (div_start)
                    begin
                        div_cnt_next = DIV_CNT_W'(DIV_STEPS);
                        state_next   = S_DIV;
                    end

                    if (fast_done)
                    begin
                        out_valid_next  = 1'b1;
                        out_duty_next   = duty_val_next;
                        out_active_next = enabled_next;
                    end
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
                else
                begin
                    // Divider finished: apply the result for the held command.
                    state_next = S_DONE;
                    unique case (arg_cmd_reg)
                        CMD_SONG:
                        begin
                            ms_period_next   = div_quo_reg;
                            half_period_next = {1'b0, rd_note.freq[15:1]};
                            cur_level_next   = rd_note.level;
                            duty_val_next    = rd_note.level;
                            enabled_next     = 1'b1;
                        end
                        CMD_SWEEP:
                        begin
                            sweep_total_next = div_quo_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BEAT:
            begin
                // Current note is on the read port.
                if (beat_inc >= rd_note.dur)
                begin
                    beat_count_next = 16'd0;
                    note_ptr_next   = ptr_wrap;
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = ptr_wrap;
                    state_next      = S_NEXT;
                end
                else
                begin
                    beat_count_next = beat_inc;
                    state_next      = S_DONE;
                end
            end
            S_NEXT:
            begin
                // A zero-frequency note wraps the song to its start.
                if (rd_note.freq == 16'd0)
                begin
                    note_ptr_next = '0;
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = '0;
                    state_next    = S_ZERO;
                end
                else
                begin
                    half_period_next = {1'b0, rd_note.freq[15:1]};
                    cur_level_next   = rd_note.level;
                    duty_val_next    = rd_note.level;
                    enabled_next     = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_ZERO:
            begin
                half_period_next = {1'b0, rd_note.freq[15:1]};
                cur_level_next   = rd_note.level;
                duty_val_next    = rd_note.level;
                enabled_next     = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_duty_next   = duty_val_reg;
                    out_active_next = enabled_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mode_reg          <= MODE_IDLE;
            half_period_reg   <= '0;
            carrier_count_reg <= '0;
            cur_level_reg     <= '0;
            duty_val_reg      <= '0;
            enabled_reg       <= 1'b0;
            ms_count_reg      <= '0;
            ms_period_reg     <= '0;
            beat_count_reg    <= '0;
            note_ptr_reg      <= '0;
            sweep_step_reg    <= '0;
            sweep_total_reg   <= '0;
            sweep_base_reg    <= '0;
            sweep_up_reg      <= 1'b0;
            sweep_level_reg   <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_duty_reg      <= '0;
            out_active_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            half_period_reg   <= half_period_next;
            carrier_count_reg <= carrier_count_next;
            cur_level_reg     <= cur_level_next;
            duty_val_reg      <= duty_val_next;
            enabled_reg       <= enabled_next;
            ms_count_reg      <= ms_count_next;
            ms_period_reg     <= ms_period_next;
            beat_count_reg    <= beat_count_next;
            note_ptr_reg      <= note_ptr_next;
            sweep_step_reg    <= sweep_step_next;
            sweep_total_reg   <= sweep_total_next;
            sweep_base_reg    <= sweep_base_next;
            sweep_up_reg      <= sweep_up_next;
            sweep_level_reg   <= sweep_level_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
            out_duty_reg      <= out_duty_next;
            out_active_reg    <= out_active_next;
        end
    end

    // Held command and the divider datapath.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            arg_cmd_reg <= cmd;
        end

        if (div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_dvd;
            div_den_reg <= div_dsr;
        end
        else if ((state_reg == S_DIV) && (div_cnt_reg != '0))
        begin
            div_rem_reg <= rem_ge ? (rem_shift - {1'b0, div_den_reg}) : rem_shift;
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], rem_ge};
        end
    end

    // The divider only counts while the sequencer waits on it.
    a_div_cnt_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> (state_reg == S_DIV))
        else $error("divider counting outside its state");

    // An accepted item either has its result ready next cycle or keeps the sequencer busy.
    a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (out_valid_reg || (state_reg != S_IDLE)))
        else $error("accepted item produced no result");

    // Sounding always belongs to a play mode.
    a_enabled_mode: assert property (@(posedge clk) disable iff (!rst_n)
        enabled_reg |-> (mode_reg != MODE_IDLE))
        else $error("carrier enabled while idle");

    // A nonzero duty only appears while the carrier is enabled.
    a_duty_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_val_reg != 8'd0) |-> enabled_reg)
        else $error("duty high while disabled");

    // The note pointer stays within the table.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        note_ptr_reg <= ADDR_W'(NOTE_DEPTH - 1))
        else $error("note pointer beyond table depth");

endmodule

// File: rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and
// holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// File: tb/pwm_tone_sequencer_tb.sv
// ----------------------------------------------------------------------------
// pwm_tone_sequencer_tb: self-checking bench for the PWM tone sequencer
// Drives command transfers through the valid/stall input channel and
// checks every duty/active transfer against a cycle-free predictor of
// the tone, song and sweep logic. A short table of directed commands comes first,
// then a song over a full table, then random command sequences with random idling.
// ----------------------------------------------------------------------------
module pwm_tone_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int NOTES        = 64;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_200_000;

    // One command transfer and one result transfer.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] freq;
        logic [7:0]  level;
        logic [15:0] duration;
        logic [15:0] speed;
        logic [7:0]  tempo_bpm;
        logic        direction;
        logic [5:0]  note_index;
    } tone_cmd_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       active;
    } pwm_out_t;

    // A directed row, with a result typed in where it is obvious.
    typedef struct {
        tone_cmd_t stim;
        bit        typed;
        pwm_out_t  result;
    } directed_row_t;

    localparam pwm_out_t SILENT = '{duty: 8'd0, active: 1'b0};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cmd_t        cmd;
    logic [15:0] freq;
    logic [7:0]  level;
    logic [15:0] duration;
    logic [15:0] speed;
    logic [7:0]  tempo_bpm;
    logic        direction;
    logic [5:0]  note_index;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  duty;
    logic        active;

    // Predicted state of the sequencer.
    logic [15:0] p_half;
    logic [15:0] p_carrier;
    logic [7:0]  p_level;
    logic [7:0]  p_duty;
    logic        p_on;
    mode_t       p_mode;
    logic [15:0] p_ms;
    logic [15:0] p_ms_period;
    logic [15:0] p_beats;
    logic [5:0]  p_ptr;
    logic [15:0] p_step;
    logic [15:0] p_steps_total;
    logic [15:0] p_sweep_base;
    logic        p_sweep_up;
    logic [7:0]  p_sweep_level;
    note_t       p_notes [NOTES];

    pwm_out_t expected_pwm [$];

    int  sent         = 0;
    int  results_seen = 0;
    int  errors       = 0;
    int  tone_ends    = 0;
    int  sweep_ends   = 0;
    int  rest_wraps   = 0;
    int  depth_wraps  = 0;
    int  gap_pct      = 0;
    int  stall_pct    = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;

    pwm_tone_sequencer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .freq       (freq),
        .level      (level),
        .duration   (duration),
        .speed      (speed),
        .tempo_bpm  (tempo_bpm),
        .direction  (direction),
        .note_index (note_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty       (duty),
        .active     (active)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predictor helpers: start sounding, and stop everything.
    function automatic void set_sound(logic [15:0] f, logic [7:0] lv);
        p_half  = f >> 1;
        p_level = lv;
        p_duty  = lv;
        p_on    = 1'b1;
    endfunction

    function automatic void go_quiet();
        p_duty = 8'd0;
        p_on   = 1'b0;
        p_mode = MODE_IDLE;
    endfunction

    // Advances the predicted state by one command and returns the result.
    function automatic pwm_out_t predict_pwm(tone_cmd_t t);
        logic [15:0] spd;
        logic [7:0]  bpm;
        logic [15:0] f;
        pwm_out_t    r;
        spd = (t.speed == '0) ? 16'd1 : t.speed;
        bpm = (t.tempo_bpm == '0) ? 8'd1 : t.tempo_bpm;
        case (t.cmd)
            CMD_CARRIER:
            begin
                if (p_on)
                begin
                    p_carrier = p_carrier + 16'd1;
                    if (p_carrier >= p_half)
                    begin
                        p_carrier = '0;
                        p_duty    = (p_duty != '0) ? 8'd0 : p_level;
                    end
                end
            end
            CMD_MS_TICK:
            begin
                if (p_mode != MODE_IDLE)
                begin
                    p_ms = p_ms + 16'd1;
                    if (p_ms >= p_ms_period)
                    begin
                        p_ms = '0;
                        case (p_mode)
                            MODE_TONE:
                            begin
                                go_quiet();
                                tone_ends++;
                            end
                            MODE_SONG:
                            begin
                                // One 1/8 beat; move on when the note has run out.
                                p_beats = p_beats + 16'd1;
                                if (p_beats >= p_notes[p_ptr].dur)
                                begin
                                    p_beats = '0;
                                    if (p_ptr == 6'(NOTES - 1))
                                        depth_wraps++;
                                    p_ptr = p_ptr + 6'd1;
                                    if (p_notes[p_ptr].freq == '0)
                                    begin
                                        if (p_ptr != '0)
                                            rest_wraps++;
                                        p_ptr = '0;
                                    end
                                    set_sound(p_notes[p_ptr].freq, p_notes[p_ptr].level);
                                end
                            end
                            default:
                            begin
                                // One sweep step, wrapping in 16 bits.
                                if (p_step < p_steps_total)
                                begin
                                    p_step  = p_step + 16'd1;
                                    f       = p_sweep_up ? p_sweep_base + p_step
                                                         : p_sweep_base - p_step;
                                    p_half  = f >> 1;
                                    p_level = p_sweep_level;
                                    if (p_step == p_steps_total)
                                    begin
                                        go_quiet();
                                        sweep_ends++;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            CMD_OFF:
                go_quiet();
            CMD_TONE:
            begin
                set_sound(t.freq, t.level);
                p_ms        = '0;
                p_ms_period = t.duration;
                p_mode      = MODE_TONE;
            end
            CMD_SONG:
            begin
                p_carrier = '0;
                set_sound(p_notes[0].freq, p_notes[0].level);
                p_ms        = '0;
                p_ms_period = 16'(MS_PER_MINUTE / (int'(bpm) << BEAT_DIV_SHIFT));
                p_beats     = '0;
                p_ptr       = '0;
                p_mode      = MODE_SONG;
            end
            CMD_SWEEP:
            begin
                p_step        = '0;
                p_steps_total = t.duration / spd;
                p_sweep_base  = t.freq;
                p_sweep_up    = t.direction;
                p_sweep_level = t.level;
                set_sound(t.freq, t.level);
                p_ms        = '0;
                p_ms_period = spd;
                p_mode      = MODE_SWEEP;
            end
            CMD_LOAD:
                p_notes[t.note_index] = {t.freq, t.level, t.duration};
            default:
            begin
            end
        endcase
        r.duty   = p_duty;
        r.active = p_on;
        return r;
    endfunction

    // Builds a command from plain numbers.
    function automatic tone_cmd_t stim(cmd_t c, int f = 0, int lv = 0, int d = 0,
                                       int s = 0, int bpm = 0, int dir = 0, int idx = 0);
        tone_cmd_t t;
        t.cmd        = c;
        t.freq       = 16'(f);
        t.level      = 8'(lv);
        t.duration   = 16'(d);
        t.speed      = 16'(s);
        t.tempo_bpm  = 8'(bpm);
        t.direction  = 1'(dir);
        t.note_index = 6'(idx);
        return t;
    endfunction

    // A command with every other field random.
    function automatic tone_cmd_t any_fields(cmd_t c);
        return stim(c, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Sends one command transfer; entered and left just after a falling edge.
    task automatic push_cmd(tone_cmd_t t, bit typed = 1'b0, pwm_out_t want = SILENT);
        int       gap;
        pwm_out_t got;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd        <= t.cmd;
        freq       <= t.freq;
        level      <= t.level;
        duration   <= t.duration;
        speed      <= t.speed;
        tempo_bpm  <= t.tempo_bpm;
        direction  <= t.direction;
        note_index <= t.note_index;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        got = predict_pwm(t);
        expected_pwm.push_back(typed ? want : got);
        sent++;
        @(negedge clk);
    endtask

    // A run of carrier and millisecond ticks, with the odd note load mixed in.
    task automatic run_ticks(int n, int ms_pct, int load_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < load_pct)
                push_cmd(any_fields(CMD_LOAD));
            else if ($urandom_range(0, 99) < ms_pct)
                push_cmd(any_fields(CMD_MS_TICK));
            else
                push_cmd(any_fields(CMD_CARRIER));
        end
    endtask

    // Chooses how often each side idles for the next stretch.
    task automatic pick_pace();
        int pace [4] = '{0, 4, 15, 35};
        gap_pct   = pace[$urandom_range(0, 3)];
        stall_pct = pace[$urandom_range(0, 3)];
    endtask

    // Output side: random stall bursts.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        pwm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_pwm.size() == 0)
            begin
                $error("result transfer with nothing expected: duty %0d active %0d",
                       duty, active);
                errors++;
            end
            else
            begin
                want = expected_pwm.pop_front();
                if (duty !== want.duty)
                begin
                    $error("duty: expected %0d, actual %0d", want.duty, duty);
                    errors++;
                end
                if (active !== want.active)
                begin
                    $error("active: expected %0d, actual %0d", want.active, active);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_pwm.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus.
    initial
    begin
        directed_row_t plan [$];
        int            rand_start;
        int            wraps_before;
        int            guard;
        int            pick;
        int            f;
        int            d;
        int            s;
        int            bpm;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_CARRIER;
        freq       = '0;
        level      = '0;
        duration   = '0;
        speed      = '0;
        tempo_bpm  = '0;
        direction  = 1'b0;
        note_index = '0;

        // Predicted state after reset.
        p_half        = '0;
        p_carrier     = '0;
        p_level       = '0;
        p_duty        = '0;
        p_on          = 1'b0;
        p_mode        = MODE_IDLE;
        p_ms          = '0;
        p_ms_period   = '0;
        p_beats       = '0;
        p_ptr         = '0;
        p_step        = '0;
        p_steps_total = '0;
        p_sweep_base  = '0;
        p_sweep_up    = 1'b0;
        p_sweep_level = '0;
        foreach (p_notes[i])
            p_notes[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: idle behavior, zero half period, tone ends, sweep
        // wraps and ends, zero steps, zero speed and tempo, loads and songs.
        plan.push_back('{stim(CMD_MS_TICK), 1'b1, SILENT});
        plan.push_back('{stim(CMD_CARRIER), 1'b1, SILENT});
        plan.push_back('{stim(CMD_OFF), 1'b1, SILENT});
        plan.push_back('{stim(CMD_TONE, 0, 255, 0), 1'b1, pwm_out_t'{8'hFF, 1'b1}});
        plan.push_back('{stim(CMD_CARRIER), 1'b1, pwm_out_t'{8'h00, 1'b1}});
        plan.push_back('{stim(CMD_CARRIER), 1'b1, pwm_out_t'{8'hFF, 1'b1}});
        plan.push_back('{stim(CMD_MS_TICK), 1'b1, SILENT});
        plan.push_back('{stim(CMD_TONE, 65535, 8'h80, 2), 1'b1, pwm_out_t'{8'h80, 1'b1}});
        plan.push_back('{stim(CMD_CARRIER), 1'b0, SILENT});
        plan.push_back('{stim(CMD_MS_TICK), 1'b0, SILENT});
        plan.push_back('{stim(CMD_MS_TICK), 1'b1, SILENT});
        plan.push_back('{stim(CMD_SWEEP, 65535, 1, 65535, 0, 0, 1), 1'b1,
                         pwm_out_t'{8'h01, 1'b1}});
        plan.push_back('{stim(CMD_MS_TICK), 1'b0, SILENT});
        plan.push_back('{stim(CMD_CARRIER), 1'b0, SILENT});
        plan.push_back('{stim(CMD_SWEEP, 0, 8'hAA, 3, 1, 0, 0), 1'b1,
                         pwm_out_t'{8'hAA, 1'b1}});
        plan.push_back('{stim(CMD_MS_TICK), 1'b0, SILENT});
        plan.push_back('{stim(CMD_MS_TICK), 1'b0, SILENT});
        plan.push_back('{stim(CMD_MS_TICK), 1'b1, SILENT});
        plan.push_back('{stim(CMD_SWEEP, 100, 7, 5, 10, 0, 1), 1'b1,
                         pwm_out_t'{8'h07, 1'b1}});
        plan.push_back('{stim(CMD_MS_TICK), 1'b0, SILENT});
        plan.push_back('{stim(CMD_LOAD, 40, 8'h55, 1, 0, 0, 0, 0), 1'b0, SILENT});
        plan.push_back('{stim(CMD_LOAD, 65535, 255, 65535, 65535, 255, 1, 63), 1'b0, SILENT});
        plan.push_back('{stim(CMD_SONG, 0, 0, 0, 0, 0), 1'b1, pwm_out_t'{8'h55, 1'b1}});
        plan.push_back('{stim(CMD_SONG, 0, 0, 0, 0, 255), 1'b1, pwm_out_t'{8'h55, 1'b1}});
        plan.push_back('{stim(CMD_OFF), 1'b1, SILENT});
        foreach (plan[i])
            push_cmd(plan[i].stim, plan[i].typed, plan[i].result);

        // Fill the whole table with no rests before any song walks it, then
        // play one song long enough to wrap at its end.
        pick_pace();
        for (int i = 0; i < NOTES; i++)
            push_cmd(stim(CMD_LOAD, $urandom_range(1, 65535), $urandom,
                          $urandom_range(0, 1), 0, 0, 0, i));
        push_cmd(stim(CMD_SONG, 0, 0, 0, 0, 255));
        wraps_before = depth_wraps;
        guard        = 0;
        while (depth_wraps == wraps_before && guard < 2600)
        begin
            run_ticks(20, 100, 0);
            guard += 20;
            if (guard % 400 == 0)
                pick_pace();
        end

        // Refill the table with some rests for the random part.
        pick_pace();
        for (int i = 0; i < NOTES; i++)
        begin
            f = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 65535);
            d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
            push_cmd(stim(CMD_LOAD, f, $urandom, d, $urandom, $urandom, $urandom, i));
        end

        // Random command sequences with random content.
        rand_start = sent;
        while (sent - rand_start < RANDOM_ITEMS)
        begin
            calm = (sent - rand_start) > (RANDOM_ITEMS - CALM_ITEMS);
            pick_pace();
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                f = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 12)
                                                : $urandom_range(0, 65535);
                d = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 65535);
                push_cmd(stim(CMD_TONE, f, $urandom, d, $urandom, $urandom, $urandom,
                              $urandom));
                run_ticks($urandom_range(5, 60), 40, 0);
            end
            else if (pick < 50)
            begin
                case ($urandom_range(0, 2))
                    0:       f = $urandom_range(0, 20);
                    1:       f = 65535 - $urandom_range(0, 20);
                    default: f = $urandom_range(0, 65535);
                endcase
                s = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 65535);
                d = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 40)
                                                : $urandom_range(0, 65535);
                push_cmd(stim(CMD_SWEEP, f, $urandom, d, s, $urandom, $urandom, $urandom));
                run_ticks($urandom_range(10, 90), 50, 0);
            end
            else if (pick < 75)
            begin
                case ($urandom_range(0, 9))
                    0:       bpm = 0;
                    1:       bpm = $urandom_range(0, 255);
                    default: bpm = $urandom_range(200, 255);
                endcase
                push_cmd(stim(CMD_SONG, $urandom, $urandom, $urandom, $urandom, bpm,
                              $urandom, $urandom));
                run_ticks($urandom_range(40, 220), 75, 3);
            end
            else if (pick < 85)
            begin
                f = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
                d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 65535);
                push_cmd(stim(CMD_LOAD, f, $urandom, d, $urandom, $urandom, $urandom,
                              $urandom));
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 6))
                    push_cmd(any_fields(cmd_t'(3'($urandom_range(0, 6)))));
            end
            else
                push_cmd(any_fields(CMD_OFF));
        end

        // Let the last results drain.
        in_valid <= 1'b0;
        while (expected_pwm.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d results in %0d cycles.",
                 sent, results_seen, cycle_count);
        $display("Tones ended %0d, sweeps ran out %0d, songs wrapped at a rest %0d, %s %0d.",
                 tone_ends, sweep_ends, rest_wraps, "at the table end", depth_wraps);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
